[rtl/core/nit_pkg.sv]
package nit_pkg;

    localparam logic [2:0] KIND_NET_HDR    = 3'd0;
    localparam logic [2:0] KIND_NET_PAY    = 3'd1;
    localparam logic [2:0] KIND_STREAM     = 3'd2;
    localparam logic [2:0] KIND_STREAM_HDR = 3'd3;
    localparam logic [2:0] KIND_STREAM_PAY = 3'd4;
    localparam logic [2:0] KIND_ACCEPT     = 3'd5;
    localparam logic [2:0] KIND_REJECT     = 3'd6;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_SHORT     = 2'd1;
    localparam logic [1:0] ERR_MISMATCH  = 2'd2;
    localparam logic [1:0] ERR_OVERRUN   = 2'd3;

    // data part bytes that are not stream loop: CRC, header, two length fields
    localparam logic signed [13:0] FIXED_OVERHEAD = 14'sd13;
    localparam logic signed [13:0] MIN_LOOP       = 14'sd6;
    localparam logic [12:0]        STREAM_HDR_LEN = 13'd6;
    localparam logic [2:0]         STREAM_HDR_LAST = 3'd5;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [7:0]  desc_tag;
        logic [7:0]  desc_length;
        logic [7:0]  payload_byte;
        logic [15:0] stream_id;
        logic [15:0] network_id;
        logic [11:0] loop_length;
        logic [1:0]  error_code;
        logic        last_of_run;
    } result_t;

endpackage

[rtl/core/nit_section_parser_core.sv]
// NIT section parser: one data-part byte per beat in, descriptor/stream records out.
// A result is written into the queue at the clock edge that accepts the byte that causes it.
// Throughput: one byte per cycle while data_ready is high; a byte that ends the loop
// emits the final record too and needs two output beats, absorbed by a 4-entry queue.
// data_ready is high while the queue has room for two results.
// Reset (rst_n low, async) empties the queue and returns the parser to idle.
module nit_section_parser_core
    import nit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic [11:0] sect_len,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  record_kind,
    output logic [7:0]  desc_tag,
    output logic [7:0]  desc_length,
    output logic [7:0]  payload_byte,
    output logic [15:0] stream_id,
    output logic [15:0] network_id,
    output logic [11:0] loop_length,
    output logic [1:0]  error_code,
    output logic        last_of_run
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_NETLEN, PH_NTAG, PH_NLEN, PH_NPAY, PH_TSLEN,
        PH_SHDR, PH_STAG, PH_SLEN, PH_SPAY, PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next, phase_eff;
    logic [2:0]  idx_reg, idx_next, idx_eff, idx_inc;
    logic [11:0] net_rem_reg, net_rem_next;
    logic [11:0] net_len_reg, net_len_next;
    logic [11:0] loop_rem_reg, loop_rem_next;
    logic [11:0] sdesc_rem_reg, sdesc_rem_next;
    logic [7:0]  left_reg, left_next;
    logic [47:0] asm_reg, asm_next, asm_shift;
    logic [11:0] sec_reg, sec_next, sec_eff;
    logic [7:0]  tag_reg, tag_next;

    logic              main_v, end_v, do_end;
    result_t           main_rec, end_rec, rec0, rec1;
    logic [11:0]       tdl_end, len_field, left_dec;
    logic [12:0]       total, loop_left, sub_amt;
    logic signed [13:0] avail;
    logic [1:0]        push_n;
    logic              accept, pop;

    result_t     q_mem [4];
    logic [1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [2:0]  count_reg;

    assign accept     = data_valid && data_ready;
    assign pop        = result_valid && result_ready;
    assign data_ready = (count_reg <= 3'd2);
    assign result_valid = (count_reg != 3'd0);

    assign phase_eff = first_byte ? PH_NETLEN : phase_reg;
    assign idx_eff   = first_byte ? 3'd0 : idx_reg;
    assign sec_eff   = first_byte ? sect_len : sec_reg;
    assign idx_inc   = idx_eff + 3'd1;
    assign asm_shift = {asm_reg[39:0], data_byte};
    assign len_field = asm_shift[11:0];
    assign left_dec  = {4'd0, left_reg - 8'd1};
    assign sub_amt   = 13'd2 + {5'd0, data_byte};
    assign avail     = $signed({2'b00, sec_eff}) - FIXED_OVERHEAD
                     - $signed({2'b00, net_len_reg});

    always_comb
    begin
        phase_next     = phase_eff;
        idx_next       = idx_eff;
        net_rem_next   = net_rem_reg;
        net_len_next   = net_len_reg;
        loop_rem_next  = loop_rem_reg;
        sdesc_rem_next = sdesc_rem_reg;
        left_next      = left_reg;
        asm_next       = asm_reg;
        sec_next       = sec_eff;
        tag_next       = tag_reg;
        main_v   = 1'b0;
        end_v    = 1'b0;
        do_end   = 1'b0;
        main_rec = '0;
        end_rec  = '0;
        tdl_end  = asm_reg[11:0];
        total    = '0;
        loop_left = '0;

        unique case (phase_eff)
            PH_NETLEN:
            begin
                asm_next = asm_shift;
                idx_next = idx_inc;
                if (idx_inc >= 3'd2)
                begin
                    net_len_next = len_field;
                    net_rem_next = len_field;
                    idx_next     = 3'd0;
                    phase_next   = (len_field == 12'd0) ? PH_TSLEN : PH_NTAG;
                end
            end
            PH_NTAG, PH_STAG:
            begin
                tag_next   = data_byte;
                phase_next = (phase_eff == PH_NTAG) ? PH_NLEN : PH_SLEN;
            end
            PH_NLEN:
            begin
                main_v = 1'b1;
                main_rec.record_kind = KIND_NET_HDR;
                main_rec.desc_tag    = tag_reg;
                main_rec.desc_length = data_byte;
                left_next = data_byte;
                net_rem_next = (sub_amt >= {1'b0, net_rem_reg}) ? 12'd0
                             : net_rem_reg - sub_amt[11:0];
                if (data_byte == 8'd0)
                    phase_next = (net_rem_next == 12'd0) ? PH_TSLEN : PH_NTAG;
                else
                    phase_next = PH_NPAY;
            end
            PH_NPAY:
            begin
                main_v = 1'b1;
                main_rec.record_kind  = KIND_NET_PAY;
                main_rec.payload_byte = data_byte;
                left_next = left_dec[7:0];
                if (left_dec == 12'd0)
                    phase_next = (net_rem_reg == 12'd0) ? PH_TSLEN : PH_NTAG;
            end
            PH_TSLEN:
            begin
                asm_next = asm_shift;
                idx_next = idx_inc;
                if (idx_inc >= 3'd2)
                begin
                    idx_next = 3'd0;
                    if (avail <= MIN_LOOP)
                    begin
                        main_v = 1'b1;
                        main_rec.record_kind = KIND_REJECT;
                        main_rec.error_code  = ERR_SHORT;
                        phase_next = PH_DONE;
                    end
                    else if (avail[11:0] != len_field)
                    begin
                        main_v = 1'b1;
                        main_rec.record_kind = KIND_REJECT;
                        main_rec.error_code  = ERR_MISMATCH;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        loop_rem_next = avail[11:0];
                        phase_next    = PH_SHDR;
                    end
                end
            end
            PH_SHDR:
            begin
                asm_next = asm_shift;
                idx_next = idx_inc;
                if (idx_eff == STREAM_HDR_LAST)
                begin
                    idx_next = 3'd0;
                    main_v = 1'b1;
                    main_rec.record_kind = KIND_STREAM;
                    main_rec.stream_id   = asm_shift[47:32];
                    main_rec.network_id  = asm_shift[31:16];
                    main_rec.loop_length = len_field;
                    sdesc_rem_next = len_field;
                    tdl_end = len_field;
                    if (len_field == 12'd0)
                        do_end = 1'b1;
                    else
                        phase_next = PH_STAG;
                end
            end
            PH_SLEN:
            begin
                main_v = 1'b1;
                main_rec.record_kind = KIND_STREAM_HDR;
                main_rec.desc_tag    = tag_reg;
                main_rec.desc_length = data_byte;
                left_next = data_byte;
                sdesc_rem_next = (sub_amt >= {1'b0, sdesc_rem_reg}) ? 12'd0
                               : sdesc_rem_reg - sub_amt[11:0];
                if (data_byte == 8'd0)
                begin
                    if (sdesc_rem_next == 12'd0)
                        do_end = 1'b1;
                    else
                        phase_next = PH_STAG;
                end
                else
                    phase_next = PH_SPAY;
            end
            PH_SPAY:
            begin
                main_v = 1'b1;
                main_rec.record_kind  = KIND_STREAM_PAY;
                main_rec.payload_byte = data_byte;
                left_next = left_dec[7:0];
                if (left_dec == 12'd0)
                begin
                    if (sdesc_rem_reg == 12'd0)
                        do_end = 1'b1;
                    else
                        phase_next = PH_STAG;
                end
            end
            default:
            begin
            end
        endcase

        // end of one stream entry: account for it against the loop
        if (do_end)
        begin
            total     = STREAM_HDR_LEN + {1'b0, tdl_end};
            loop_left = {1'b0, loop_rem_reg} - total;
            if (total > {1'b0, loop_rem_reg})
            begin
                end_v = 1'b1;
                end_rec.record_kind = KIND_REJECT;
                end_rec.error_code  = ERR_OVERRUN;
                phase_next = PH_DONE;
            end
            else
            begin
                loop_rem_next = loop_left[11:0];
                if (loop_left == 13'd0)
                begin
                    end_v = 1'b1;
                    end_rec.record_kind = KIND_ACCEPT;
                    phase_next = PH_DONE;
                end
                else
                begin
                    phase_next = PH_SHDR;
                    idx_next   = 3'd0;
                end
            end
        end
    end

    always_comb
    begin
        rec0 = main_v ? main_rec : end_rec;
        rec1 = end_rec;
        rec0.last_of_run = !(main_v && end_v);
        rec1.last_of_run = 1'b1;
        push_n = accept ? ({1'b0, main_v} + {1'b0, end_v}) : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            idx_reg       <= '0;
            net_rem_reg   <= '0;
            net_len_reg   <= '0;
            loop_rem_reg  <= '0;
            sdesc_rem_reg <= '0;
            left_reg      <= '0;
            asm_reg       <= '0;
            sec_reg       <= '0;
            tag_reg       <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                idx_reg       <= idx_next;
                net_rem_reg   <= net_rem_next;
                net_len_reg   <= net_len_next;
                loop_rem_reg  <= loop_rem_next;
                sdesc_rem_reg <= sdesc_rem_next;
                left_reg      <= left_next;
                asm_reg       <= asm_next;
                sec_reg       <= sec_next;
                tag_reg       <= tag_next;
            end
            wr_ptr_reg <= wr_ptr_reg + push_n;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + {1'b0, push_n} - {2'b00, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            q_mem[wr_ptr_reg] <= rec0;
        if (push_n == 2'd2)
            q_mem[wr_ptr_reg + 2'd1] <= rec1;
    end

    assign record_kind  = q_mem[rd_ptr_reg].record_kind;
    assign desc_tag     = q_mem[rd_ptr_reg].desc_tag;
    assign desc_length  = q_mem[rd_ptr_reg].desc_length;
    assign payload_byte = q_mem[rd_ptr_reg].payload_byte;
    assign stream_id    = q_mem[rd_ptr_reg].stream_id;
    assign network_id   = q_mem[rd_ptr_reg].network_id;
    assign loop_length  = q_mem[rd_ptr_reg].loop_length;
    assign error_code   = q_mem[rd_ptr_reg].error_code;
    assign last_of_run  = q_mem[rd_ptr_reg].last_of_run;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count_reg == $past(count_reg) + {1'b0, $past(push_n)}
                             - {2'b00, $past(pop)})
        else $error("queue count out of step with pushes and pops");

    a_pair_final: assert property (@(posedge clk) disable iff (!rst_n)
        push_n == 2'd2 |-> (rec1.record_kind == KIND_ACCEPT
                            || rec1.record_kind == KIND_REJECT))
        else $error("second result of a beat is not a final record");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !first_byte && (phase_reg == PH_IDLE || phase_reg == PH_DONE))
        |-> push_n == 2'd0)
        else $error("result produced outside a section");
`endif

endmodule

[dv/nit_section_parser_core_tb.sv]
`timescale 1ns / 1ps

module nit_section_parser_core_tb
    import nit_pkg::*;
();

    localparam int HDR_CRC_BYTES    = 13;
    localparam int MIN_STREAM_LOOP  = 6;
    localparam int STREAM_HDR_BYTES = 6;
    localparam int ITEM_TARGET      = 1200;
    localparam int CALM_AFTER       = 1050;
    localparam int IDLE_LIMIT       = 2000;
    localparam int REPORT_LIMIT     = 10;

    typedef enum logic [3:0] {
        WAIT_SECTION,
        NET_LEN,
        NET_TAG,
        NET_DLEN,
        NET_PAYLOAD,
        TS_LEN,
        TS_HEADER,
        TS_TAG,
        TS_DLEN,
        TS_PAYLOAD,
        SECTION_DONE
    } parse_phase_e;

    typedef enum int {
        SEC_GOOD,
        SEC_OVERSHOOT,
        SEC_OVERRUN,
        SEC_MISMATCH,
        SEC_SHORT,
        SEC_TRUNCATED,
        SEC_NOISE
    } section_flavor_e;

    class nit_record_board;
        parse_phase_e phase;
        bit [2:0]     hdr_index;
        bit [13:0]    net_left;
        bit [11:0]    net_len;
        bit [13:0]    loop_left;
        bit [13:0]    ts_desc_left;
        bit [7:0]     bytes_left;
        bit [47:0]    assembly;
        bit [11:0]    slen_held;
        bit [7:0]     tag_held;
        result_t      expected_q[$];
        int           mismatches;

        function new();
            clear_parse();
            mismatches = 0;
        endfunction

        function void clear_parse();
            phase        = WAIT_SECTION;
            hdr_index    = '0;
            net_left     = '0;
            net_len      = '0;
            loop_left    = '0;
            ts_desc_left = '0;
            bytes_left   = '0;
            assembly     = '0;
            slen_held    = '0;
            tag_held     = '0;
        endfunction

        function void push_record(logic [2:0] kind, logic [7:0] tag, logic [7:0] len,
                                  logic [7:0] pay, logic [15:0] sid, logic [15:0] nid,
                                  logic [11:0] ll, logic [1:0] err);
            result_t r;
            r.record_kind  = kind;
            r.desc_tag     = tag;
            r.desc_length  = len;
            r.payload_byte = pay;
            r.stream_id    = sid;
            r.network_id   = nid;
            r.loop_length  = ll;
            r.error_code   = err;
            r.last_of_run  = 1'b0;
            expected_q.insert(expected_q.size(), r);
        endfunction

        function bit [13:0] minus_sat(bit [13:0] a, int b);
            return (b >= int'(a)) ? 14'd0 : a - 14'(b);
        endfunction

        function void net_loop_next();
            if (net_left == 0)
            begin
                phase     = TS_LEN;
                hdr_index = '0;
                assembly  = '0;
            end
            else
            begin
                phase = NET_TAG;
            end
        endfunction

        // header total uses the declared descriptors length, not the bytes walked
        function void stream_close();
            int total;
            total = STREAM_HDR_BYTES + int'(assembly[11:0]);
            if (total > int'(loop_left))
            begin
                push_record(KIND_REJECT, '0, '0, '0, '0, '0, '0, ERR_OVERRUN);
                phase = SECTION_DONE;
            end
            else
            begin
                loop_left = loop_left - 14'(total);
                if (loop_left == 0)
                begin
                    push_record(KIND_ACCEPT, '0, '0, '0, '0, '0, '0, ERR_NONE);
                    phase = SECTION_DONE;
                end
                else
                begin
                    phase     = TS_HEADER;
                    hdr_index = '0;
                    assembly  = '0;
                end
            end
        endfunction

        function void stream_desc_next();
            if (ts_desc_left == 0)
                stream_close();
            else
                phase = TS_TAG;
        endfunction

        function void note_byte(bit [7:0] b, bit first, bit [11:0] slen);
            int prior_count;
            int avail;
            prior_count = expected_q.size();
            if (first)
            begin
                clear_parse();
                phase     = NET_LEN;
                slen_held = slen;
            end
            unique case (phase)
                NET_LEN:
                begin
                    assembly = {assembly[39:0], b};
                    hdr_index++;
                    if (hdr_index >= 2)
                    begin
                        net_len   = assembly[11:0];
                        net_left  = {2'b00, net_len};
                        hdr_index = '0;
                        net_loop_next();
                    end
                end
                NET_TAG:
                begin
                    tag_held = b;
                    phase    = NET_DLEN;
                end
                NET_DLEN:
                begin
                    push_record(KIND_NET_HDR, tag_held, b, '0, '0, '0, '0, ERR_NONE);
                    bytes_left = b;
                    net_left   = minus_sat(net_left, 2 + int'(b));
                    if (b == 0)
                        net_loop_next();
                    else
                        phase = NET_PAYLOAD;
                end
                NET_PAYLOAD:
                begin
                    push_record(KIND_NET_PAY, '0, '0, b, '0, '0, '0, ERR_NONE);
                    bytes_left--;
                    if (bytes_left == 0)
                        net_loop_next();
                end
                TS_LEN:
                begin
                    assembly = {assembly[39:0], b};
                    hdr_index++;
                    if (hdr_index >= 2)
                    begin
                        avail     = int'(slen_held) - HDR_CRC_BYTES - int'(net_len);
                        hdr_index = '0;
                        if (avail <= MIN_STREAM_LOOP)
                        begin
                            push_record(KIND_REJECT, '0, '0, '0, '0, '0, '0, ERR_SHORT);
                            phase = SECTION_DONE;
                        end
                        else if (avail != int'(assembly[11:0]))
                        begin
                            push_record(KIND_REJECT, '0, '0, '0, '0, '0, '0, ERR_MISMATCH);
                            phase = SECTION_DONE;
                        end
                        else
                        begin
                            loop_left = 14'(avail);
                            phase     = TS_HEADER;
                            assembly  = '0;
                        end
                    end
                end
                TS_HEADER:
                begin
                    assembly = {assembly[39:0], b};
                    hdr_index++;
                    if (hdr_index >= STREAM_HDR_BYTES)
                    begin
                        hdr_index = '0;
                        push_record(KIND_STREAM, '0, '0, '0, assembly[47:32], assembly[31:16],
                                    assembly[11:0], ERR_NONE);
                        ts_desc_left = {2'b00, assembly[11:0]};
                        stream_desc_next();
                    end
                end
                TS_TAG:
                begin
                    tag_held = b;
                    phase    = TS_DLEN;
                end
                TS_DLEN:
                begin
                    push_record(KIND_STREAM_HDR, tag_held, b, '0, '0, '0, '0, ERR_NONE);
                    bytes_left   = b;
                    ts_desc_left = minus_sat(ts_desc_left, 2 + int'(b));
                    if (b == 0)
                        stream_desc_next();
                    else
                        phase = TS_PAYLOAD;
                end
                TS_PAYLOAD:
                begin
                    push_record(KIND_STREAM_PAY, '0, '0, b, '0, '0, '0, ERR_NONE);
                    bytes_left--;
                    if (bytes_left == 0)
                        stream_desc_next();
                end
                default:
                begin
                end
            endcase
            if (expected_q.size() > prior_count)
                expected_q[expected_q.size() - 1].last_of_run = 1'b1;
        endfunction

        function string show(result_t r);
            return $sformatf({"kind=%0d tag=%02h len=%02h pay=%02h sid=%04h nid=%04h ",
                              "ll=%03h err=%0d last=%0b"},
                             r.record_kind, r.desc_tag, r.desc_length, r.payload_byte,
                             r.stream_id, r.network_id, r.loop_length, r.error_code,
                             r.last_of_run);
        endfunction

        function void check_record(result_t got);
            result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: %0t unexpected record: %s", $realtime, show(got));
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("ERROR: %0t record mismatch", $realtime);
                        $display("    expected: %s", show(want));
                        $display("    actual:   %s", show(got));
                    end
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        data_valid;
    logic        data_ready;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [11:0] sect_len;
    logic        result_valid;
    logic        result_ready;
    logic [2:0]  record_kind;
    logic [7:0]  desc_tag;
    logic [7:0]  desc_length;
    logic [7:0]  payload_byte;
    logic [15:0] stream_id;
    logic [15:0] network_id;
    logic [11:0] loop_length;
    logic [1:0]  error_code;
    logic        last_of_run;

    nit_record_board board = new();

    bit [7:0]  section_bytes[$];
    bit [11:0] section_slen;
    int        bytes_sent = 0;
    bit        calm = 1'b0;
    bit        drained = 1'b0;

    nit_section_parser_core dut (.*);

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_record({record_kind, desc_tag, desc_length, payload_byte, stream_id,
                                network_id, loop_length, error_code, last_of_run});
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_byte(bit [7:0] b, bit start, bit [11:0] slen);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            data_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= b;
        first_byte <= start;
        sect_len   <= slen;
        @(posedge clk);
        while (!data_ready)
            @(posedge clk);
        board.note_byte(b, start, slen);
        bytes_sent++;
        calm = (bytes_sent >= CALM_AFTER);
        @(negedge clk);
    endtask

    task automatic send_section(bit with_start);
        foreach (section_bytes[i])
            send_byte(section_bytes[i], with_start && i == 0, section_slen);
    endtask

    function automatic void add_descriptors(ref bit [7:0] dst[$], input int count,
                                            output int total, output int last_size);
        int len;
        total     = 0;
        last_size = 0;
        repeat (count)
        begin
            len = ($urandom_range(0, 79) == 0) ? 255 : $urandom_range(0, 5);
            dst.insert(dst.size(), 8'($urandom));
            dst.insert(dst.size(), 8'(len));
            repeat (len)
                dst.insert(dst.size(), 8'($urandom));
            total     += 2 + len;
            last_size = 2 + len;
        end
    endfunction

    function automatic void build_section(section_flavor_e flavor);
        bit [7:0]  net_part[$];
        bit [7:0]  ts_part[$];
        bit [7:0]  desc_part[$];
        bit [11:0] tsl_field;
        int        net_actual;
        int        net_decl;
        int        last_size;
        int        tdl_actual;
        int        tdl_decl;
        int        loop_total;
        int        loop_decl;
        int        slen;
        int        keep;
        section_bytes.delete();
        if (flavor == SEC_NOISE)
        begin
            section_slen = 12'($urandom);
            repeat ($urandom_range(1, 10))
                section_bytes.insert(section_bytes.size(), 8'($urandom));
            return;
        end
        add_descriptors(net_part, $urandom_range(0, 3), net_actual, last_size);
        net_decl = net_actual;
        // declared count ends inside the last descriptor, which is still read whole
        if (flavor == SEC_OVERSHOOT && net_actual > 0)
            net_decl = net_actual - $urandom_range(1, last_size - 1);
        loop_total = 0;
        repeat ($urandom_range(1, 3))
        begin
            desc_part.delete();
            add_descriptors(desc_part, $urandom_range(0, 2), tdl_actual, last_size);
            tdl_decl = tdl_actual;
            if (flavor == SEC_OVERSHOOT && tdl_actual > 0 && $urandom_range(0, 1) == 1)
                tdl_decl = tdl_actual - $urandom_range(1, last_size - 1);
            repeat (4)
                ts_part.insert(ts_part.size(), 8'($urandom));
            ts_part.insert(ts_part.size(), {4'($urandom), 4'(tdl_decl >> 8)});
            ts_part.insert(ts_part.size(), 8'(tdl_decl));
            foreach (desc_part[i])
                ts_part.insert(ts_part.size(), desc_part[i]);
            loop_total += STREAM_HDR_BYTES + tdl_decl;
        end
        loop_decl = loop_total;
        // loop shorter than the streams: last stream runs past the end
        if (flavor == SEC_OVERRUN)
            loop_decl = loop_total - $urandom_range(1, 5);
        slen      = HDR_CRC_BYTES + net_decl + loop_decl;
        tsl_field = 12'(loop_decl);
        if (flavor == SEC_MISMATCH)
            tsl_field = tsl_field ^ 12'($urandom_range(1, 4095));
        if (flavor == SEC_SHORT)
        begin
            slen      = $urandom_range(0, HDR_CRC_BYTES + MIN_STREAM_LOOP + net_decl);
            tsl_field = 12'($urandom);
        end
        section_slen = 12'(slen);
        section_bytes.insert(section_bytes.size(), {4'($urandom), 4'(net_decl >> 8)});
        section_bytes.insert(section_bytes.size(), 8'(net_decl));
        foreach (net_part[i])
            section_bytes.insert(section_bytes.size(), net_part[i]);
        section_bytes.insert(section_bytes.size(), {4'($urandom), tsl_field[11:8]});
        section_bytes.insert(section_bytes.size(), tsl_field[7:0]);
        foreach (ts_part[i])
            section_bytes.insert(section_bytes.size(), ts_part[i]);
        // CRC plus a little trailing junk
        repeat ($urandom_range(4, 6))
            section_bytes.insert(section_bytes.size(), 8'($urandom));
        if (flavor == SEC_TRUNCATED)
        begin
            keep = $urandom_range(1, section_bytes.size() - 1);
            while (section_bytes.size() > keep)
                void'(section_bytes.pop_back());
        end
    endfunction

    initial
    begin
        int stall_left;
        stall_left   = 0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                result_ready <= 1'b0;
                stall_left   = $urandom_range(1, 9) - 1;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((data_valid && data_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("nit_section_parser_core test failed");
        $finish;
    end

    initial
    begin
        section_flavor_e flavor;
        int              roll;
        rst_n      = 1'b0;
        data_valid = 1'b0;
        data_byte  = '0;
        first_byte = 1'b0;
        sect_len   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // stray bytes before any section
        section_bytes = '{8'h00, 8'hFF};
        section_slen  = 12'hFFF;
        send_section(1'b0);
        // empty section length: stream loop too short
        section_bytes = '{8'h00, 8'h00, 8'hF0, 8'h00};
        section_slen  = 12'h000;
        send_section(1'b1);
        // largest section length, loop length disagrees
        section_bytes = '{8'hF0, 8'h00, 8'hFF, 8'hFF};
        section_slen  = 12'hFFF;
        send_section(1'b1);
        // dropped mid-descriptor by the next section start
        section_bytes = '{8'hF0, 8'h05, 8'hAA};
        section_slen  = 12'd100;
        send_section(1'b1);
        // minimal accepted section, stream descriptor overshoots its count
        section_bytes = '{8'hF0, 8'h02, 8'hFF, 8'h00, 8'hF0, 8'h07,
                          8'h00, 8'h00, 8'hFF, 8'hFF, 8'hF0, 8'h01, 8'h00, 8'h00,
                          8'h12, 8'h34, 8'h56, 8'h78};
        section_slen  = 12'd22;
        send_section(1'b1);

        while (bytes_sent < ITEM_TARGET)
        begin
            if (!drained && bytes_sent >= ITEM_TARGET / 2)
            begin
                data_valid <= 1'b0;
                while (board.expected_q.size() != 0)
                    @(negedge clk);
                @(negedge clk);
                drained = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 55)
                flavor = SEC_GOOD;
            else if (roll < 65)
                flavor = SEC_OVERSHOOT;
            else if (roll < 72)
                flavor = SEC_OVERRUN;
            else if (roll < 79)
                flavor = SEC_MISMATCH;
            else if (roll < 85)
                flavor = SEC_SHORT;
            else if (roll < 93)
                flavor = SEC_TRUNCATED;
            else
                flavor = SEC_NOISE;
            build_section(flavor);
            send_section(1'b1);
        end
        data_valid <= 1'b0;

        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (board.mismatches == 0)
            $display("nit_section_parser_core test passed");
        else
            $display("nit_section_parser_core test failed");
        $finish;
    end

endmodule
